### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the picker datapath; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define WRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled while reset is low
`define WRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define WRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/wrp_pkg.sv
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wrp_pkg;

  localparam int WEIGHT_W   = 24;
  localparam int TOTAL_W    = 32;
  localparam int RND_W      = 32;
  localparam int MODE_W     = 2;
  localparam int MCNT_W     = 7;
  localparam int OUT_IDX_W  = 6;
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [WEIGHT_W-1:0] BAL_INIT   = 24'd10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 24'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 24'hFFFFFF;

  localparam logic [MODE_W-1:0] MODE_BALANCED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RANDOM    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NO_REPEAT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_PICKED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALL_DRAWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RESET     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INIT      = 2'd3;

  localparam logic CMD_PICK = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_PLAY_MODE    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MEMBER_COUNT = 1'b1;

  typedef logic [2:0] op_t;
  localparam op_t OP_NONE = 3'd0;
  localparam op_t OP_FILL = 3'd1;
  localparam op_t OP_SUM  = 3'd2;
  localparam op_t OP_WALK = 3'd3;
  localparam op_t OP_BAL  = 3'd4;
  localparam op_t OP_ZERO = 3'd5;

  typedef struct packed {
    logic clr;
    op_t  op;
    logic fill_one;
    logic div_start;
    logic div_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic pass_done;
    logic total_zero;
    logic hit;
    logic div_busy;
  } dp_stat_t;

endpackage

### src/wrp_ram.sv
// ----------------------------------------------------------------------------
// wrp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wrp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/wrp_div.sv
// ----------------------------------------------------------------------------
// wrp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wrp_pkg::TOTAL_W-1:0] dividend,
  input  logic [wrp_pkg::TOTAL_W-1:0] divisor,
  output logic                        busy,
  output logic [wrp_pkg::TOTAL_W-1:0] quotient,
  output logic [wrp_pkg::TOTAL_W-1:0] remainder
);
  import wrp_pkg::*;

  localparam int CNT_W = $clog2(TOTAL_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0] quo_r, quo_nxt;
  logic [TOTAL_W-1:0] rem_r, rem_nxt;
  logic [TOTAL_W-1:0] div_r, div_nxt;
  logic [TOTAL_W:0]   trial;
  logic [TOTAL_W:0]   diff;
  logic               fits;

  always_comb begin
    trial    = {rem_r, quo_r[TOTAL_W-1]};
    diff     = trial - {1'b0, div_r};
    fits     = (trial >= {1'b0, div_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(TOTAL_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
      quo_nxt = {quo_r[TOTAL_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### src/wrp_ctrl.sv
// ----------------------------------------------------------------------------
// wrp_ctrl
// Sequencer for clear, init, sum, draw, walk, weight update and zero passes.
// ----------------------------------------------------------------------------
module wrp_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  logic                         in_cmd,
  input  logic [wrp_pkg::MODE_W-1:0]   play_mode,
  input  logic                         out_free,
  input  wrp_pkg::dp_stat_t            dp_stat,
  output wrp_pkg::dp_cmd_t             dp_cmd,
  output logic                         in_ready,
  output logic                         res_load,
  output logic [wrp_pkg::STATUS_W-1:0] res_status
);
  import wrp_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_DIV_R = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_DIV_S = 4'd6;
  localparam logic [3:0] S_BAL   = 4'd7;
  localparam logic [3:0] S_ZERO  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]          st_r, st_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;

  always_comb begin
    st_nxt   = st_r;
    code_nxt = code_r;
    dp_cmd   = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    case (st_r)
      S_CLEAR: begin
        dp_cmd.op = OP_FILL;
        if (dp_stat.pass_done) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_accept) begin
          dp_cmd.clr = 1'b1;
          if (in_cmd == CMD_INIT) begin
            code_nxt = ST_INIT;
            st_nxt   = S_FILL;
          end else begin
            st_nxt = S_SUM;
          end
        end
      end
      S_FILL: begin
        dp_cmd.op       = OP_FILL;
        dp_cmd.fill_one = (play_mode != MODE_BALANCED);
        if (dp_stat.pass_done) begin
          st_nxt = S_DONE;
        end
      end
      S_SUM: begin
        dp_cmd.op = OP_SUM;
        if (dp_stat.pass_done) begin
          if (dp_stat.total_zero) begin
            if (play_mode == MODE_NO_REPEAT) begin
              code_nxt = ST_ALL_DRAWN;
              st_nxt   = S_DONE;
            end else begin
              code_nxt   = ST_RESET;
              dp_cmd.clr = 1'b1;
              st_nxt     = S_FILL;
            end
          end else begin
            dp_cmd.div_start = 1'b1;
            dp_cmd.clr       = 1'b1;
            st_nxt           = S_DIV_R;
          end
        end
      end
      S_DIV_R: begin
        if (!dp_stat.div_busy) begin
          st_nxt = S_WALK;
        end
      end
      S_WALK: begin
        dp_cmd.op = OP_WALK;
        if (dp_stat.hit) begin
          code_nxt = ST_PICKED;
          case (play_mode)
            MODE_BALANCED: begin
              dp_cmd.div_start = 1'b1;
              dp_cmd.div_sel   = 1'b1;
              dp_cmd.clr       = 1'b1;
              st_nxt           = S_DIV_S;
            end
            MODE_NO_REPEAT: st_nxt = S_ZERO;
            default:        st_nxt = S_DONE;
          endcase
        end
      end
      S_DIV_S: begin
        if (!dp_stat.div_busy) begin
          st_nxt = S_BAL;
        end
      end
      S_BAL: begin
        dp_cmd.op = OP_BAL;
        if (dp_stat.pass_done) begin
          st_nxt = S_DONE;
        end
      end
      S_ZERO: begin
        dp_cmd.op = OP_ZERO;
        st_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res_load = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      code_r <= ST_PICKED;
    end else begin
      st_r   <= st_nxt;
      code_r <= code_nxt;
    end
  end

  assign res_status = code_r;

endmodule

### src/wrp_dp.sv
// ----------------------------------------------------------------------------
// wrp_dp
// Weight store, pass counter, accumulator, walk compare, update adder and divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrp_dp #(
  parameter int MAX_MEMBERS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wrp_pkg::dp_cmd_t             cmd,
  output wrp_pkg::dp_stat_t            stat,
  input  logic                         in_load,
  input  logic [wrp_pkg::RND_W-1:0]    in_rnd,
  input  logic [wrp_pkg::MCNT_W-1:0]   member_count,
  output logic [$clog2(MAX_MEMBERS)-1:0] pick_idx
);
  import wrp_pkg::*;

  localparam int IDX_W = $clog2(MAX_MEMBERS);
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

  logic [CNT_W-1:0]    n_w;
  logic [CNT_W-1:0]    limit;
  logic                at_limit;
  logic                issuing;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                vld_r, vld_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    pidx_r;
  logic [TOTAL_W-1:0]  acc_r, acc_nxt;
  logic [IDX_W-1:0]    pick_r, pick_nxt;
  logic [WEIGHT_W-1:0] wpick_r, wpick_nxt;
  logic [WEIGHT_W-1:0] sr_r;
  logic [RND_W-1:0]    rnd_r;
  logic [TOTAL_W-1:0]  run;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WEIGHT_W-1:0] ram_wdata;
  logic [WEIGHT_W-1:0] ram_rdata;

  logic [TOTAL_W-1:0]  div_dividend;
  logic [TOTAL_W-1:0]  div_divisor;
  logic                div_busy;
  logic [TOTAL_W-1:0]  div_quo;
  logic [TOTAL_W-1:0]  div_rem;

  logic                is_chosen;
  logic [WEIGHT_W:0]   upd_base;
  logic [WEIGHT_W:0]   upd_add;
  logic [WEIGHT_W:0]   upd_sum;

  // members in use, clamped to 1..MAX_MEMBERS
  always_comb begin
    if (member_count == '0) begin
      n_w = CNT_W'(1);
    end else if (32'(member_count) > MAX_MEMBERS) begin
      n_w = CNT_W'(MAX_MEMBERS);
    end else begin
      n_w = CNT_W'(member_count);
    end
  end

  assign limit    = (cmd.op == OP_FILL) ? CNT_W'(MAX_MEMBERS) : n_w;
  assign at_limit = (idx_r == limit);
  assign issuing  = ((cmd.op == OP_SUM) || (cmd.op == OP_BAL) ||
                     ((cmd.op == OP_WALK) && !hit_r)) && !at_limit;
  assign run      = acc_r + TOTAL_W'(ram_rdata);

  always_comb begin
    idx_nxt   = idx_r;
    vld_nxt   = issuing;
    hit_nxt   = hit_r;
    acc_nxt   = acc_r;
    pick_nxt  = pick_r;
    wpick_nxt = wpick_r;
    if (cmd.clr) begin
      idx_nxt = '0;
      vld_nxt = 1'b0;
      hit_nxt = 1'b0;
      acc_nxt = '0;
    end else begin
      if (issuing || ((cmd.op == OP_FILL) && !at_limit)) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
      if (vld_r && (cmd.op == OP_SUM)) begin
        acc_nxt = run;
      end
      if (vld_r && (cmd.op == OP_WALK) && !hit_r) begin
        acc_nxt = run;
        // r = random mod total + 1, so run >= r is run > remainder
        if (run > div_rem) begin
          hit_nxt   = 1'b1;
          pick_nxt  = pidx_r;
          wpick_nxt = ram_rdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= idx_r[IDX_W-1:0];
    acc_r   <= acc_nxt;
    pick_r  <= pick_nxt;
    wpick_r <= wpick_nxt;
    sr_r    <= div_quo[WEIGHT_W-1:0] + div_rem[WEIGHT_W-1:0];
    if (in_load) begin
      rnd_r <= in_rnd;
    end
  end

  // balanced update: chosen becomes 1 + share + rest, others gain share
  assign is_chosen = (pidx_r == pick_r);
  assign upd_base  = is_chosen ? (WEIGHT_W+1)'(WEIGHT_ONE) : {1'b0, ram_rdata};
  assign upd_add   = is_chosen ? {1'b0, sr_r} : {1'b0, div_quo[WEIGHT_W-1:0]};
  assign upd_sum   = upd_base + upd_add;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[IDX_W-1:0];
    ram_wdata = cmd.fill_one ? WEIGHT_ONE : BAL_INIT;
    case (cmd.op)
      OP_FILL: ram_we = !at_limit;
      OP_BAL: begin
        ram_we    = vld_r;
        ram_waddr = pidx_r;
        ram_wdata = upd_sum[WEIGHT_W] ? WEIGHT_MAX : upd_sum[WEIGHT_W-1:0];
      end
      OP_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = pick_r;
        ram_wdata = '0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  wrp_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_MEMBERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign div_dividend = cmd.div_sel ? (TOTAL_W'(wpick_r) - TOTAL_W'(1)) : rnd_r;
  assign div_divisor  = cmd.div_sel ? TOTAL_W'(n_w) : acc_r;

  wrp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign stat.pass_done  = at_limit && !vld_r;
  assign stat.total_zero = (acc_r == '0);
  assign stat.hit        = hit_r;
  assign stat.div_busy   = div_busy;
  assign pick_idx        = pick_r;

  `WRP_ASSERT_IMPL(a_div_start_idle, clk, rst_n, cmd.div_start, !div_busy, "divider restarted while busy")
  `WRP_ASSERT_IMPL(a_pick_in_range, clk, rst_n, (cmd.op == OP_WALK) && hit_r, CNT_W'(pick_r) < n_w, "picked index beyond members in use")
  `WRP_ASSERT_IMPL(a_write_in_range, clk, rst_n, ram_we, CNT_W'(ram_waddr) < limit, "weight write outside pass range")
  `WRP_ASSERT_NEXT(a_sum_no_wrap, clk, rst_n, (cmd.op == OP_SUM) && vld_r && !cmd.clr, acc_r >= $past(acc_r), "weight total wrapped")

endmodule

### src/weighted_random_picker.sv
// ----------------------------------------------------------------------------
// weighted_random_picker
// Roulette-wheel selection over a table of per-member weights.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata = random_value[31:0], tuser = cmd
//  out_    | master    | tdata = chosen_index[5:0] + 2 zero bits, tuser = status
//  cfg_    | write     | addr 0 play_mode, addr 1 member_count
//
//  A pick makes up to three passes over the n weight RAM entries in use (sum,
//  walk, balanced update), plus two divider runs (draw modulo and share
//  split).
//  An init command fills all MAX_MEMBERS entries; an empty-total reset runs
//  the sum pass first and then the same fill.
//  After reset a clearing pass writes 10000 into every entry; in_tready
//  stays low until it ends, configuration writes are taken.
//  A finished result waits in the output register while the next transaction
//  is accepted; a stalled output holds the following result in the sequencer.
// ----------------------------------------------------------------------------
module weighted_random_picker #(
  parameter int MAX_MEMBERS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wrp_pkg::RND_W-1:0]      in_tdata,   // [31:0] random_value
  input  logic [0:0]                     in_tuser,   // [0] cmd
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wrp_pkg::OUT_DATA_W-1:0] out_tdata,  // [5:0] chosen_index, [7:6] zero
  output logic [wrp_pkg::STATUS_W-1:0]   out_tuser,  // [1:0] status
  // configuration
  input  logic                           cfg_we,
  input  logic [wrp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wrp_pkg::*;

  localparam int IDX_W = $clog2(MAX_MEMBERS);

  logic [MODE_W-1:0]    play_mode_r, play_mode_nxt;
  logic [MCNT_W-1:0]    member_count_r, member_count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [STATUS_W-1:0]  out_status_r;

  dp_cmd_t              dp_cmd;
  dp_stat_t             dp_stat;
  logic                 in_ready;
  logic                 in_accept;
  logic                 out_free;
  logic                 res_load;
  logic [STATUS_W-1:0]  res_status;
  logic [IDX_W-1:0]     pick_idx;
  logic [IDX_W+OUT_IDX_W-1:0] pick_ext;

  assign in_accept = in_tvalid && in_ready;
  assign in_tready = in_ready;
  // output slot frees up when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;

  // configuration registers
  always_comb begin
    play_mode_nxt    = play_mode_r;
    member_count_nxt = member_count_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_PLAY_MODE:    play_mode_nxt    = cfg_wdata[MODE_W-1:0];
        REG_MEMBER_COUNT: member_count_nxt = cfg_wdata[MCNT_W-1:0];
        default:          play_mode_nxt    = play_mode_r;
      endcase
    end
  end

  // hold result until the downstream side takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_mode_r    <= MODE_BALANCED;
      member_count_r <= MCNT_W'(64);
      out_valid_r    <= 1'b0;
    end else begin
      play_mode_r    <= play_mode_nxt;
      member_count_r <= member_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // chosen index is masked to 6 bits and zero unless a member was picked
  assign pick_ext = {{OUT_IDX_W{1'b0}}, pick_idx};

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_idx_r    <= (res_status == ST_PICKED) ? pick_ext[OUT_IDX_W-1:0] : '0;
    end
  end

  wrp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_cmd     (in_tuser[0]),
    .play_mode  (play_mode_r),
    .out_free   (out_free),
    .dp_stat    (dp_stat),
    .dp_cmd     (dp_cmd),
    .in_ready   (in_ready),
    .res_load   (res_load),
    .res_status (res_status)
  );

  wrp_dp #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .in_load      (in_accept),
    .in_rnd       (in_tdata),
    .member_count (member_count_r),
    .pick_idx     (pick_idx)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-OUT_IDX_W)'(0), out_idx_r};
  assign out_tuser  = out_status_r;

endmodule

### tb/sv/weighted_random_picker_test.sv
// ----------------------------------------------------------------------------
// weighted_random_picker_test
// Self-checking bench for the roulette-wheel picker. A directed table covers
// reset weights, draw extremes, every play mode, the unused mode, clamped
// member counts, exhausted avoid-repeat tables and the empty-total reset.
// Random phases follow: each one usually reconfigures the idle block, usually
// reinitializes it, then runs a burst of draws. Every result is checked
// against a typed expectation or a local copy of the weight table.
// ----------------------------------------------------------------------------
module weighted_random_picker_test;
  import wrp_pkg::*;

  localparam int          MEMBERS      = 64;
  localparam int          RANDOM_ITEMS = 1330;
  localparam int          CFG_SETTLE   = 8;
  // settle time that covers a full-table pick with some margin
  localparam int          END_SETTLE   = 400;
  localparam longint      CYCLE_LIMIT  = 3_000_000;
  localparam logic [23:0] WEIGHT_SAT   = 24'hFFFFFF;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic [STATUS_W-1:0]  status;
  } draw_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one line of the directed table; for ROW_CFG, sel is the register index
  // and value the write data, for ROW_ITEM sel is the command
  typedef struct packed {
    row_kind_t   kind;
    logic        sel;
    logic [31:0] value;
    logic        known;
    draw_t       want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [RND_W-1:0]      in_tdata;   // [31:0] random_value
  logic [0:0]            in_tuser;   // [0] cmd
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [5:0] chosen_index, [7:6] zero
  logic [STATUS_W-1:0]   out_tuser;  // [1:0] status
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // local copy of the block state
  logic [WEIGHT_W-1:0] weight_tbl [MEMBERS];
  logic [MODE_W-1:0]   cur_mode;
  logic [MCNT_W-1:0]   cur_count;

  draw_t     pending_draws[$];
  stim_row_t directed_rows[$];
  int        mismatch_count;
  int        items_sent;
  int        ready_hold;
  bit        steady;
  longint    cycle_count;

  weighted_random_picker #(
    .MAX_MEMBERS(MEMBERS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Weight table model
  // --------------------------------------------------------------------------

  // Reload every entry, including those outside the members in use.
  function automatic void refill_weights();
    for (int i = 0; i < MEMBERS; i++) begin
      weight_tbl[i] = (cur_mode == MODE_BALANCED) ? BAL_INIT : WEIGHT_ONE;
    end
  endfunction

  function automatic logic [WEIGHT_W-1:0] clamp_weight(longint unsigned sum);
    return (sum > WEIGHT_SAT) ? WEIGHT_SAT : sum[WEIGHT_W-1:0];
  endfunction

  // Work out the result of one command and advance the local state.
  function automatic draw_t predict_draw(logic cmd, logic [RND_W-1:0] rnd);
    draw_t           res;
    int unsigned     n;
    int unsigned     pick;
    bit              hit;
    longint unsigned total;
    longint unsigned target;
    longint unsigned run;
    longint unsigned lost;
    longint unsigned share;
    longint unsigned rem;

    res.index  = '0;
    res.status = ST_PICKED;
    // a member count of zero acts as one, anything past the table as all
    n = (cur_count == 0) ? 1 : ((cur_count > MEMBERS) ? MEMBERS : cur_count);
    if (cmd == CMD_INIT) begin
      refill_weights();
      res.status = ST_INIT;
      return res;
    end

    total = 0;
    for (int i = 0; i < n; i++) total += weight_tbl[i];
    if (total == 0) begin
      if (cur_mode == MODE_NO_REPEAT) begin
        res.status = ST_ALL_DRAWN;
      end else begin
        refill_weights();
        res.status = ST_RESET;
      end
      return res;
    end

    // walk the running sum until it reaches the drawn ticket
    target = longint'(rnd) % total + 1;
    run    = 0;
    pick   = 0;
    hit    = 1'b0;
    for (int i = 0; i < n; i++) begin
      run += weight_tbl[i];
      if (!hit && run >= target) begin
        pick = i;
        hit  = 1'b1;
      end
    end

    if (cur_mode == MODE_BALANCED) begin
      // spread what the winner lost over all members, remainder back to it
      lost  = weight_tbl[pick] - 1;
      share = lost / n;
      rem   = lost - share * n;
      weight_tbl[pick] = WEIGHT_ONE;
      for (int i = 0; i < n; i++) weight_tbl[i] = clamp_weight(weight_tbl[i] + share);
      weight_tbl[pick] = clamp_weight(weight_tbl[pick] + rem);
    end else if (cur_mode == MODE_NO_REPEAT) begin
      weight_tbl[pick] = '0;
    end
    // fully random and the unused mode leave the table alone

    res.index = pick[OUT_IDX_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly no gap, sometimes a few cycles, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one command, hold it until the block takes the transaction,
  // then queue what it should produce.
  task automatic send_item(logic cmd, logic [RND_W-1:0] rnd, bit known, draw_t typed);
    int    gap;
    draw_t modeled;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      in_tdata  = $urandom;
      in_tuser  = 1'($urandom_range(0, 1));
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = rnd;
    do @(posedge clk); while (!in_tready);
    modeled = predict_draw(cmd, rnd);
    pending_draws.insert(pending_draws.size(), known ? typed : modeled);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result to come back.
  task automatic drain(int settle);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Single-cycle register write; only called with the block idle.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = wdata;
    if (addr == REG_PLAY_MODE) cur_mode = wdata[MODE_W-1:0];
    else cur_count = wdata;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_item(logic cmd, logic [31:0] rnd, bit known,
                          logic [OUT_IDX_W-1:0] idx, logic [STATUS_W-1:0] st);
    stim_row_t line;
    line.kind        = ROW_ITEM;
    line.sel         = cmd;
    line.value       = rnd;
    line.known       = known;
    line.want.index  = idx;
    line.want.status = st;
    directed_rows.insert(directed_rows.size(), line);
  endtask

  task automatic add_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
    stim_row_t line;
    line.kind  = ROW_CFG;
    line.sel   = addr;
    line.value = 32'(wdata);
    line.known = 1'b0;
    line.want  = '0;
    directed_rows.insert(directed_rows.size(), line);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the scoreboard
  // --------------------------------------------------------------------------

  initial begin
    out_tready = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_tready = 1'b1;
      end else if (ready_hold > 0) begin
        out_tready = 1'b0;
        ready_hold--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_result
    draw_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result index %0d status %0d", $time,
                 out_tdata[OUT_IDX_W-1:0], out_tuser);
        mismatch_count++;
      end else begin
        want = pending_draws.pop_front();
        if (out_tdata[OUT_IDX_W-1:0] !== want.index) begin
          $display("%0t: chosen_index expected %0d actual %0d", $time,
                   want.index, out_tdata[OUT_IDX_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[OUT_DATA_W-1:OUT_IDX_W] !== '0) begin
          $display("%0t: tdata pad expected 0 actual %0d", $time,
                   out_tdata[OUT_DATA_W-1:OUT_IDX_W]);
          mismatch_count++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("weighted_random_picker_test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int              burst;
    int unsigned     members;
    int unsigned     roll;
    logic [MODE_W-1:0] mode_pick;
    logic [CFG_DATA_W-1:0] count_pick;
    stim_row_t       row;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    steady    = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    cur_mode  = MODE_BALANCED;
    cur_count = 7'(MEMBERS);
    for (int i = 0; i < MEMBERS; i++) weight_tbl[i] = BAL_INIT;

    // Directed table. Typed expectations only where they are obvious.
    // fresh table of 10000s: the smallest draw lands on member 0
    add_item(CMD_PICK, 32'h0000_0000, 1, 0, ST_PICKED);
    add_item(CMD_PICK, 32'hFFFF_FFFF, 0, 0, ST_PICKED);
    add_item(CMD_INIT, 32'hFFFF_FFFF, 1, 0, ST_INIT);
    // single member in avoid-repeat: one pick, then the table is exhausted
    add_cfg(REG_PLAY_MODE, 7'(MODE_NO_REPEAT));
    add_cfg(REG_MEMBER_COUNT, 7'd1);
    add_item(CMD_INIT, 32'h0000_0000, 1, 0, ST_INIT);
    add_item(CMD_PICK, 32'h1234_5678, 1, 0, ST_PICKED);
    add_item(CMD_PICK, 32'hFFFF_FFFF, 1, 0, ST_ALL_DRAWN);
    // mode change keeps the zero weight, so balanced sees an empty total
    add_cfg(REG_PLAY_MODE, 7'(MODE_BALANCED));
    add_item(CMD_PICK, 32'h0000_0000, 1, 0, ST_RESET);
    add_item(CMD_PICK, 32'hFFFF_FFFF, 1, 0, ST_PICKED);
    // member count of zero acts as one
    add_cfg(REG_MEMBER_COUNT, 7'd0);
    add_item(CMD_PICK, 32'h8000_0000, 1, 0, ST_PICKED);
    // three members drawn out, then exhausted
    add_cfg(REG_PLAY_MODE, 7'(MODE_NO_REPEAT));
    add_cfg(REG_MEMBER_COUNT, 7'd3);
    add_item(CMD_INIT, 32'h0000_0001, 1, 0, ST_INIT);
    add_item(CMD_PICK, 32'hDEAD_BEEF, 0, 0, ST_PICKED);
    add_item(CMD_PICK, 32'h0000_0000, 0, 0, ST_PICKED);
    add_item(CMD_PICK, 32'hFFFF_FFFF, 0, 0, ST_PICKED);
    add_item(CMD_PICK, 32'h0000_0007, 1, 0, ST_ALL_DRAWN);
    // fully random on an empty table resets to ones; then ticket 3 of 3
    add_cfg(REG_PLAY_MODE, 7'(MODE_RANDOM));
    add_item(CMD_PICK, 32'h0000_0000, 1, 0, ST_RESET);
    add_item(CMD_PICK, 32'h0000_0002, 1, 2, ST_PICKED);
    // all-ones write data: unused mode 3, member count clamped to 64
    add_cfg(REG_PLAY_MODE, 7'h7F);
    add_cfg(REG_MEMBER_COUNT, 7'h7F);
    add_item(CMD_INIT, 32'hAAAA_5555, 1, 0, ST_INIT);
    add_item(CMD_PICK, 32'h0000_003F, 1, 63, ST_PICKED);
    add_item(CMD_PICK, 32'hFFFF_FFFF, 1, 63, ST_PICKED);
    // balanced on a table of ones: nothing to redistribute
    add_cfg(REG_PLAY_MODE, 7'(MODE_BALANCED));
    add_cfg(REG_MEMBER_COUNT, 7'd64);
    add_item(CMD_PICK, 32'h5555_AAAA, 0, 0, ST_PICKED);
    add_item(CMD_INIT, 32'h0000_0000, 1, 0, ST_INIT);

    // hold reset, then release; the clearing pass keeps in_tready low a while
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) begin
        drain(CFG_SETTLE);
        write_reg(row.sel, row.value[CFG_DATA_W-1:0]);
      end else begin
        send_item(row.sel, row.value, row.known, row.want);
      end
    end

    // Random phases: mostly reconfigure while idle, usually reinitialize, then a
    // burst. Avoid-repeat bursts run past exhaustion on purpose; skipping
    // the init on the next phase lets a new mode meet an empty table.
    while (items_sent < RANDOM_ITEMS + directed_rows.size()) begin
      drain(CFG_SETTLE);
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        mode_pick = 2'($urandom_range(0, 3));
        write_reg(REG_PLAY_MODE, {($urandom_range(0, 1) ? 5'($urandom) : 5'd0), mode_pick});
      end
      if ($urandom_range(0, 4) != 0) begin
        // keep most phases small: a pick walks the weights of every member
        roll = $urandom_range(0, 19);
        if (roll < 13)      count_pick = 7'($urandom_range(1, 8));
        else if (roll < 17) count_pick = 7'($urandom_range(9, 32));
        else if (roll == 17) count_pick = 7'd64;
        else if (roll == 18) count_pick = 7'd0;
        else                count_pick = 7'($urandom_range(65, 127));
        write_reg(REG_MEMBER_COUNT, count_pick);
      end
      if ($urandom_range(0, 4) != 0) send_item(CMD_INIT, $urandom, 0, '0);

      members = (cur_count == 0) ? 1 : ((cur_count > MEMBERS) ? MEMBERS : cur_count);
      if (cur_mode == MODE_NO_REPEAT) burst = members + $urandom_range(1, 3);
      else burst = $urandom_range(8, 40);
      repeat (burst) begin
        send_item(($urandom_range(0, 29) == 0) ? CMD_INIT : CMD_PICK, $urandom, 0, '0);
      end
    end

    // let every result return, then allow one full pick of quiet time
    drain(END_SETTLE);
    if (mismatch_count == 0) begin
      $display("weighted_random_picker_test passed");
    end else begin
      $display("weighted_random_picker_test failed");
    end
    $finish;
  end

endmodule
